/* hdl/nif_pkg.sv */
// ----------------------------------------------------------------------------
// nif_pkg: shared types and constants for the four-point Newton interpolator
// Register indexes, sequencer states and a signed 32-bit clamp helper.
// ----------------------------------------------------------------------------
package nif_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned Points      = 4;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned CfgIdxW     = 4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_NODE_X0 = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_NODE_Y0 = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_COUNT   = 4'd8;

  // Coefficient setup sequencer
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_CHECK,
    SEQ_LOAD,
    SEQ_DIV
  } seq_state_e;

  // Clamp a wide signed value to 32 bits; MSB of the result flags a clamp
  function automatic logic [DataW:0] sat32(input logic signed [63:0] v);
    logic [DataW:0] r;
    begin
      if (v > 64'sd2147483647) begin
        r = {1'b1, 32'h7fff_ffff};
      end else if (v < -64'sd2147483648) begin
        r = {1'b1, 32'h8000_0000};
      end else begin
        r = {1'b0, v[DataW-1:0]};
      end
      return r;
    end
  endfunction

endpackage

/* hdl/newton_interp_four_point_core.sv */
// ----------------------------------------------------------------------------
// newton_interp_four_point_core: cubic Newton interpolation at a query point
// Evaluates the cubic through four configured nodes in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Write node abscissas (index 0..3) and ordinates (index 4..7) on the
//   cfg port while the block is idle. Each valid write starts a coefficient
//   setup run: a bit-serial divider forms the six divided differences, one
//   after another, and in_stall_o stays high until the run ends, or only in
//   the check state when two abscissas repeat. The divider retires one
//   quotient bit per cycle. Query channel: query_x_i moves on a transfer
//   (in_valid_i high, in_stall_o low). Each query gives one result on the
//   output channel; one query per cycle is sustained, while the output does
//   not stall and no setup run is active, through eight register stages
//   (difference, three multiply/scale pairs, one per term order, final sum).
//   A stalled output holds its result; stages with bubbles keep filling, so
//   the input keeps taking transfers until every stage holds an item.
//   Reset loads nodes at 0, 1, 2, 3 with zero ordinates; the matching
//   coefficients are all zero, so no setup run follows reset.
// ----------------------------------------------------------------------------
module newton_interp_four_point_core #(
  parameter int unsigned FRAC_BITS = nif_pkg::FracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nif_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [nif_pkg::DataW-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [nif_pkg::DataW-1:0]  query_x_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [nif_pkg::DataW-1:0]  interp_y_o,
  output logic                              div_by_zero_o,
  output logic                              saturated_o
);
  import nif_pkg::*;

  localparam int unsigned NumW   = 33 + FRAC_BITS;
  localparam int unsigned CntW   = $clog2(NumW + 1);
  localparam int unsigned Stages = 8;
  localparam logic signed [63:0] RoundAdj = (64'sd1 <<< FRAC_BITS) - 64'sd1;
  localparam logic [NumW-1:0] LimPos = NumW'(33'h0_7fff_ffff);
  localparam logic [NumW-1:0] LimNeg = NumW'(33'h0_8000_0000);

  // Product scaled down by 2^FRAC_BITS, truncated toward zero, clamped
  function automatic logic [DataW:0] fx_scale(input logic signed [63:0] p);
    logic signed [63:0] adj;
    logic signed [63:0] sh;
    begin
      adj = p + (p[63] ? RoundAdj : 64'sd0);
      sh  = adj >>> FRAC_BITS;
      return sat32(sh);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Node registers
  // --------------------------------------------------------------------------
  logic signed [DataW-1:0] node_x_q [Points];
  logic signed [DataW-1:0] node_y_q [Points];
  logic                    cfg_hit;

  assign cfg_hit = cfg_we_i && (cfg_idx_i < REG_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Points; i++) begin
        node_y_q[i] <= '0;
      end
      node_x_q[0] <= 32'sd0;
      node_x_q[1] <= 32'sd65536;
      node_x_q[2] <= 32'sd131072;
      node_x_q[3] <= 32'sd196608;
    end else if (cfg_hit) begin
      if (cfg_idx_i < REG_NODE_Y0) begin
        node_x_q[cfg_idx_i[1:0]] <= cfg_wdata_i;
      end else begin
        node_y_q[cfg_idx_i[1:0]] <= cfg_wdata_i;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Coefficient setup: six divided differences through one serial divider
  // coef order: f0 (c1), f1, f2, g0 (c2), g1, c3
  // --------------------------------------------------------------------------
  seq_state_e              seq_q, seq_d;
  logic signed [DataW-1:0] coef_q [6];
  logic [2:0]              step_q, step_d;
  logic [NumW-1:0]         num_q, num_d;
  logic [32:0]             rem_q, rem_d;
  logic [32:0]             den_q, den_d;
  logic [NumW-1:0]         quo_q, quo_d;
  logic                    neg_q, neg_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    dz_q, dz_d;
  logic                    satc_q, satc_d;
  logic                    coef_we;
  logic signed [DataW-1:0] coef_wval;
  logic signed [32:0]      op_num, op_den;
  logic [32:0]             num_mag, den_mag;
  logic [33:0]             trial;
  logic                    nodes_dup;

  assign nodes_dup = (node_x_q[0] == node_x_q[1]) || (node_x_q[1] == node_x_q[2]) ||
                     (node_x_q[2] == node_x_q[3]) || (node_x_q[0] == node_x_q[2]) ||
                     (node_x_q[1] == node_x_q[3]) || (node_x_q[0] == node_x_q[3]);

  // Select the operands of the current step
  always_comb begin
    case (step_q)
      3'd0: begin
        op_num = {node_y_q[1][31], node_y_q[1]} - {node_y_q[0][31], node_y_q[0]};
        op_den = {node_x_q[1][31], node_x_q[1]} - {node_x_q[0][31], node_x_q[0]};
      end
      3'd1: begin
        op_num = {node_y_q[2][31], node_y_q[2]} - {node_y_q[1][31], node_y_q[1]};
        op_den = {node_x_q[2][31], node_x_q[2]} - {node_x_q[1][31], node_x_q[1]};
      end
      3'd2: begin
        op_num = {node_y_q[3][31], node_y_q[3]} - {node_y_q[2][31], node_y_q[2]};
        op_den = {node_x_q[3][31], node_x_q[3]} - {node_x_q[2][31], node_x_q[2]};
      end
      3'd3: begin
        op_num = {coef_q[1][31], coef_q[1]} - {coef_q[0][31], coef_q[0]};
        op_den = {node_x_q[2][31], node_x_q[2]} - {node_x_q[0][31], node_x_q[0]};
      end
      3'd4: begin
        op_num = {coef_q[2][31], coef_q[2]} - {coef_q[1][31], coef_q[1]};
        op_den = {node_x_q[3][31], node_x_q[3]} - {node_x_q[1][31], node_x_q[1]};
      end
      default: begin
        op_num = {coef_q[4][31], coef_q[4]} - {coef_q[3][31], coef_q[3]};
        op_den = {node_x_q[3][31], node_x_q[3]} - {node_x_q[0][31], node_x_q[0]};
      end
    endcase
    num_mag = op_num[32] ? 33'(-op_num) : 33'(op_num);
    den_mag = op_den[32] ? 33'(-op_den) : 33'(op_den);
  end

  assign trial = {rem_q, num_q[NumW-1]};

  // Sequencer next state, divider step and result clamp
  always_comb begin
    seq_d     = seq_q;
    step_d    = step_q;
    num_d     = num_q;
    rem_d     = rem_q;
    den_d     = den_q;
    quo_d     = quo_q;
    neg_d     = neg_q;
    cnt_d     = cnt_q;
    dz_d      = dz_q;
    satc_d    = satc_q;
    coef_we   = 1'b0;
    coef_wval = '0;
    unique case (seq_q)
      SEQ_IDLE: ;
      SEQ_CHECK: begin
        dz_d   = nodes_dup;
        satc_d = 1'b0;
        step_d = '0;
        seq_d  = nodes_dup ? SEQ_IDLE : SEQ_LOAD;
      end
      SEQ_LOAD: begin
        num_d = {num_mag, FRAC_BITS'(0)};
        den_d = den_mag;
        neg_d = op_num[32] ^ op_den[32];
        rem_d = '0;
        quo_d = '0;
        cnt_d = CntW'(NumW);
        seq_d = SEQ_DIV;
      end
      SEQ_DIV: begin
        if (trial >= {1'b0, den_q}) begin
          rem_d = 33'(trial - {1'b0, den_q});
          quo_d = {quo_q[NumW-2:0], 1'b1};
        end else begin
          rem_d = trial[32:0];
          quo_d = {quo_q[NumW-2:0], 1'b0};
        end
        num_d = {num_q[NumW-2:0], 1'b0};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          // Clamp the finished quotient and store it
          coef_we = 1'b1;
          if (neg_q) begin
            if (quo_d > LimNeg) begin
              coef_wval = 32'sh8000_0000;
              satc_d    = 1'b1;
            end else begin
              coef_wval = DataW'(~quo_d[31:0] + 32'd1);
            end
          end else begin
            if (quo_d > LimPos) begin
              coef_wval = 32'sh7fff_ffff;
              satc_d    = 1'b1;
            end else begin
              coef_wval = quo_d[31:0];
            end
          end
          step_d = step_q + 3'd1;
          seq_d  = (step_q == 3'd5) ? SEQ_IDLE : SEQ_LOAD;
        end
      end
      default: seq_d = SEQ_IDLE;
    endcase
    // Any node write restarts the setup run
    if (cfg_hit) begin
      seq_d = SEQ_CHECK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= SEQ_IDLE;
      step_q <= '0;
      cnt_q  <= '0;
      dz_q   <= 1'b0;
      satc_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        coef_q[i] <= '0;
      end
    end else begin
      seq_q  <= seq_d;
      step_q <= step_d;
      cnt_q  <= cnt_d;
      dz_q   <= dz_d;
      satc_q <= satc_d;
      if (coef_we) begin
        coef_q[step_q] <= coef_wval;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  // --------------------------------------------------------------------------
  // Evaluation pipeline
  // --------------------------------------------------------------------------
  logic [Stages:1] v_q;
  logic [Stages:1] en;
  logic            in_xfer;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[Stages] = !v_q[Stages] || !out_stall_i;
    for (int k = Stages - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[1] || (seq_q != SEQ_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= in_xfer;
      end
      for (int k = 2; k <= Stages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  logic signed [DataW-1:0] dx0_1_q, dx1_1_q, dx2_1_q;
  logic                    sat1_q;
  logic [DataW:0]          cl_dx0, cl_dx1, cl_dx2;

  // Stage 1: offsets from the first three nodes
  assign cl_dx0 = sat32(64'(query_x_i) - 64'(node_x_q[0]));
  assign cl_dx1 = sat32(64'(query_x_i) - 64'(node_x_q[1]));
  assign cl_dx2 = sat32(64'(query_x_i) - 64'(node_x_q[2]));

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      dx0_1_q <= cl_dx0[DataW-1:0];
      dx1_1_q <= cl_dx1[DataW-1:0];
      dx2_1_q <= cl_dx2[DataW-1:0];
      sat1_q  <= cl_dx0[DataW] | cl_dx1[DataW] | cl_dx2[DataW];
    end
  end

  // Stage 2: first-order term and first factor product
  logic signed [63:0]      pt1_2_q, pq1_2_q;
  logic signed [DataW-1:0] dx2_2_q;
  logic                    sat2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      pt1_2_q <= 64'(coef_q[0]) * 64'(dx0_1_q);
      pq1_2_q <= 64'(dx0_1_q) * 64'(dx1_1_q);
      dx2_2_q <= dx2_1_q;
      sat2_q  <= sat1_q;
    end
  end

  // Stage 3: scale both products
  logic signed [DataW-1:0] t1_3_q, q1_3_q, dx2_3_q;
  logic                    sat3_q;
  logic [DataW:0]          sc_t1, sc_q1;

  assign sc_t1 = fx_scale(pt1_2_q);
  assign sc_q1 = fx_scale(pq1_2_q);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      t1_3_q  <= sc_t1[DataW-1:0];
      q1_3_q  <= sc_q1[DataW-1:0];
      dx2_3_q <= dx2_2_q;
      sat3_q  <= sat2_q | sc_t1[DataW] | sc_q1[DataW];
    end
  end

  // Stage 4: second-order term, second factor product, partial sum
  logic signed [63:0] pt2_4_q, pq2_4_q;
  logic signed [32:0] s1_4_q;
  logic               sat4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      pt2_4_q <= 64'(coef_q[3]) * 64'(q1_3_q);
      pq2_4_q <= 64'(q1_3_q) * 64'(dx2_3_q);
      s1_4_q  <= 33'(node_y_q[0]) + 33'(t1_3_q);
      sat4_q  <= sat3_q;
    end
  end

  // Stage 5: scale both products
  logic signed [DataW-1:0] t2_5_q, q2_5_q;
  logic signed [32:0]      s1_5_q;
  logic                    sat5_q;
  logic [DataW:0]          sc_t2, sc_q2;

  assign sc_t2 = fx_scale(pt2_4_q);
  assign sc_q2 = fx_scale(pq2_4_q);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      t2_5_q <= sc_t2[DataW-1:0];
      q2_5_q <= sc_q2[DataW-1:0];
      s1_5_q <= s1_4_q;
      sat5_q <= sat4_q | sc_t2[DataW] | sc_q2[DataW];
    end
  end

  // Stage 6: third-order term and partial sum
  logic signed [63:0] pt3_6_q;
  logic signed [33:0] s2_6_q;
  logic               sat6_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      pt3_6_q <= 64'(coef_q[5]) * 64'(q2_5_q);
      s2_6_q  <= 34'(s1_5_q) + 34'(t2_5_q);
      sat6_q  <= sat5_q;
    end
  end

  // Stage 7: scale the third-order term
  logic signed [DataW-1:0] t3_7_q;
  logic signed [33:0]      s2_7_q;
  logic                    sat7_q;
  logic [DataW:0]          sc_t3;

  assign sc_t3 = fx_scale(pt3_6_q);

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      t3_7_q <= sc_t3[DataW-1:0];
      s2_7_q <= s2_6_q;
      sat7_q <= sat6_q | sc_t3[DataW];
    end
  end

  // Stage 8: final sum, clamp and flags
  logic signed [DataW-1:0] y_8_q;
  logic                    dz_8_q, sat_8_q;
  logic [DataW:0]          cl_sum;

  assign cl_sum = sat32(64'(s2_7_q) + 64'(t3_7_q));

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      if (dz_q) begin
        y_8_q   <= '0;
        dz_8_q  <= 1'b1;
        sat_8_q <= 1'b0;
      end else begin
        y_8_q   <= cl_sum[DataW-1:0];
        dz_8_q  <= 1'b0;
        sat_8_q <= sat7_q | cl_sum[DataW] | satc_q;
      end
    end
  end

  assign out_valid_o   = v_q[Stages];
  assign interp_y_o    = y_8_q;
  assign div_by_zero_o = dz_8_q;
  assign saturated_o   = sat_8_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_dz_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_by_zero_o |-> (interp_y_o == '0) && !saturated_o)
    else $error("repeated node result not zero or flagged saturated");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (seq_q == SEQ_CHECK) && in_stall_o)
    else $error("node write did not restart coefficient setup");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_DIV) |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

endmodule

/* bench/tb_newton_interp_four_point_core.sv */
// ----------------------------------------------------------------------------
// tb_newton_interp_four_point_core: self-checking bench for the interpolator
// Writes node sets, sends directed and random query abscissas with random
// idling on both channels, and checks every result against a table or model.
// ----------------------------------------------------------------------------
module tb_newton_interp_four_point_core;
  timeunit 1ns;
  timeprecision 1ps;
  import nif_pkg::*;

  localparam int FracBits = 16;
  localparam int NodeIdx  = 4;

  typedef struct packed {
    logic signed [31:0] y;
    logic               dz;
    logic               sat;
  } interp_res_t;

  typedef struct {
    logic [31:0] qx;
    logic        known;
    interp_res_t res;
  } query_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [DataW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [DataW-1:0] query_x_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DataW-1:0] interp_y_o;
  logic div_by_zero_o;
  logic saturated_o;

  // Local copy of the node registers
  logic signed [31:0] node_x [NodeIdx];
  logic signed [31:0] node_y [NodeIdx];

  interp_res_t expected_q [$];
  int errors = 0;
  bit calm = 1'b0;

  always #1 clk_i = ~clk_i;

  newton_interp_four_point_core #(.FRAC_BITS(FracBits)) DUT (.*);

  function automatic logic signed [63:0] clamp_w(input logic signed [63:0] v, inout bit s);
    if (v > 64'sd2147483647) begin
      s = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      s = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic signed [63:0] ddiv(input logic signed [63:0] n,
                                              input logic signed [63:0] d, inout bit s);
    logic signed [63:0] sc;
    sc = n * 64'sd65536;
    return clamp_w(sc / d, s);
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b, inout bit s);
    logic signed [63:0] p;
    p = a * b;
    return clamp_w(p / 64'sd65536, s);
  endfunction

  // Evaluate the Newton cubic at one abscissa
  function automatic interp_res_t newton_eval(input logic signed [31:0] qx);
    interp_res_t r;
    bit s;
    logic signed [63:0] x0, x1, x2, x3, d10, d21, d32, d20, d31, d30;
    logic signed [63:0] f0, f1, f2, g0, g1, c3, a0, a1, a2, q1, q2, t1, t2, t3, sm;
    s = 1'b0;
    x0 = node_x[0]; x1 = node_x[1]; x2 = node_x[2]; x3 = node_x[3];
    d10 = x1 - x0; d21 = x2 - x1; d32 = x3 - x2;
    d20 = x2 - x0; d31 = x3 - x1; d30 = x3 - x0;
    if (d10 == 0 || d21 == 0 || d32 == 0 || d20 == 0 || d31 == 0 || d30 == 0) begin
      r.y = '0; r.dz = 1'b1; r.sat = 1'b0;
      return r;
    end
    f0 = ddiv(64'(node_y[1]) - node_y[0], d10, s);
    f1 = ddiv(64'(node_y[2]) - node_y[1], d21, s);
    f2 = ddiv(64'(node_y[3]) - node_y[2], d32, s);
    g0 = ddiv(f1 - f0, d20, s);
    g1 = ddiv(f2 - f1, d31, s);
    c3 = ddiv(g1 - g0, d30, s);
    a0 = clamp_w(64'(qx) - x0, s);
    a1 = clamp_w(64'(qx) - x1, s);
    a2 = clamp_w(64'(qx) - x2, s);
    t1 = qmul(f0, a0, s);
    q1 = qmul(a0, a1, s);
    t2 = qmul(g0, q1, s);
    q2 = qmul(q1, a2, s);
    t3 = qmul(c3, q2, s);
    sm = clamp_w(64'(node_y[0]) + t1 + t2 + t3, s);
    r.y = sm[31:0]; r.dz = 1'b0; r.sat = s;
    return r;
  endfunction

  // Write one node register, then wait out the coefficient setup
  task automatic write_node(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < REG_NODE_Y0) node_x[idx[1:0]] = val;
    else if (idx < REG_COUNT) node_y[idx[1:0]] = val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop the input valid and let the pipeline drain before touching the nodes
  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // Drive one query transfer, with an optional idle burst first
  task automatic send_query(input logic [31:0] qx, input bit known,
                            input interp_res_t res);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    query_x_i <= qx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (known) expected_q.push_back(res);
    else expected_q.push_back(newton_eval(qx));
  endtask

  function automatic logic [31:0] rand_node;
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      1: return $urandom;
      default: return 32'($signed($urandom_range(0, 16 * 65536)) - 8 * 65536);
    endcase
  endfunction

  function automatic logic [31:0] rand_query;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 12 * 65536)) - 4 * 65536);
    endcase
  endfunction

  // Pick and load a new node set; some sets repeat an abscissa
  task automatic load_nodes(input int kind);
    logic [31:0] v;
    drain();
    for (int i = 0; i < 2 * NodeIdx; i++) begin
      if (kind == 0) v = (i < NodeIdx) ? 32'(i * 65536 * ($urandom_range(1, 3))) : rand_node();
      else if (kind == 1) v = rand_node();
      else v = (i < NodeIdx) ? 32'(65536 * $urandom_range(0, 2)) : rand_node();
      if (i > 0 && i < NodeIdx && kind == 0) v = v + node_x[i - 1];
      write_node(CfgIdxW'(i), v);
    end
  endtask

  // Output side: random stall bursts, compare every result
  always @(posedge clk_i) begin
    interp_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result y=%h dz=%b sat=%b", $realtime, interp_y_o,
                 div_by_zero_o, saturated_o);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (interp_y_o !== e.y || div_by_zero_o !== e.dz || saturated_o !== e.sat) begin
          $display("%0t: mismatch expected y=%h dz=%b sat=%b actual y=%h dz=%b sat=%b",
                   $realtime, e.y, e.dz, e.sat, interp_y_o, div_by_zero_o, saturated_o);
          errors++;
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk_i) begin
    if (calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  query_row_t dir_rows [14];
  interp_res_t zero_res;

  initial begin
    zero_res = '0;
    node_x[0] = 0; node_x[1] = 65536; node_x[2] = 131072; node_x[3] = 196608;
    for (int i = 0; i < NodeIdx; i++) node_y[i] = 0;
    // After reset all coefficients vanish, so y is zero
    dir_rows[0] = '{32'h0000_0000, 1'b1, zero_res};
    dir_rows[1] = '{32'h7fff_ffff, 1'b1, interp_res_t'{32'sh0, 1'b0, 1'b1}};
    dir_rows[2] = '{32'h8000_0000, 1'b1, interp_res_t'{32'sh0, 1'b0, 1'b1}};
    dir_rows[3] = '{32'h0001_8000, 1'b1, zero_res};
    for (int i = 4; i < 14; i++) dir_rows[i] = '{32'h0, 1'b0, zero_res};
    dir_rows[4].qx = 32'h0000_0000;
    dir_rows[5].qx = 32'h0001_0000;
    dir_rows[6].qx = 32'h7fff_ffff;
    dir_rows[7].qx = 32'h8000_0000;
    dir_rows[8].qx = 32'hffff_ffff;
    dir_rows[9].qx = 32'h0002_8000;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 4; i++) send_query(dir_rows[i].qx, dir_rows[i].known, dir_rows[i].res);
    // Cubic y = x^3 on nodes 0..3, plus extreme ordinates later
    drain();
    write_node(REG_NODE_Y0 + 4'd1, 32'h0001_0000);
    write_node(REG_NODE_Y0 + 4'd2, 32'h0008_0000);
    write_node(REG_NODE_Y0 + 4'd3, 32'h001b_0000);
    for (int i = 4; i < 10; i++) send_query(dir_rows[i].qx, 1'b0, zero_res);
    drain();
    write_node(REG_NODE_Y0, 32'h7fff_ffff);
    write_node(REG_NODE_Y0 + 4'd3, 32'h8000_0000);
    send_query(32'h0001_0000, 1'b0, zero_res);
    send_query(32'h8000_0000, 1'b0, zero_res);
    // Repeated abscissa: flag set, value zero
    drain();
    write_node(REG_NODE_X0 + 4'd2, 32'h0001_0000);
    send_query(32'h1234_5678, 1'b1, interp_res_t'{32'sh0, 1'b1, 1'b0});
    send_query(32'h8000_0000, 1'b1, interp_res_t'{32'sh0, 1'b1, 1'b0});
    // Out-of-range and extreme abscissas
    drain();
    write_node(REG_NODE_X0, 32'h8000_0000);
    write_node(REG_NODE_X0 + 4'd3, 32'h7fff_ffff);
    send_query(32'h7fff_ffff, 1'b0, zero_res);
    send_query(32'h0000_0000, 1'b0, zero_res);
    // Write to an index past the register file: ignored
    drain();
    write_node(REG_COUNT + 4'd1, 32'hdead_beef);
    // Random part: node sets and query bursts
    for (int n = 0; n < 830; n++) begin
      if (n % 40 == 0) load_nodes((n / 40) % 5 == 4 ? 2 : (n / 40) % 2);
      if (n == 800) calm = 1'b1;
      send_query(rand_query(), 1'b0, zero_res);
    end
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
hdl/nif_pkg.sv
hdl/newton_interp_four_point_core.sv
bench/tb_newton_interp_four_point_core.sv
